// ----- sv/msq_pkg.sv -----
`default_nettype none
package msq_pkg;
	localparam int NumQueues = 1024;
	localparam int PoolNodes = 2048;
	localparam int ValueBits = 31;
	localparam int QueueBits = 10;
	localparam int NodeBits = 12;
	localparam logic [NodeBits-1:0] NilNode = NodeBits'(PoolNodes);

	typedef enum logic [1:0] {
		OP_MERGE = 2'd0,
		OP_POP = 2'd1,
		OP_INSERT = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [QueueBits-1:0] queue_a;
		logic [QueueBits-1:0] queue_b;
		logic [ValueBits-1:0] item_value;
	} in_item_t;

	typedef struct packed {
		logic [ValueBits-1:0] popped_value;
		logic [1:0] status;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HEADS,
		S_ALLOC,
		S_INS_RD,
		S_INS_CHK,
		S_POP_RD,
		S_MRG_RD,
		S_MRG_CHK,
		S_OUT
	} state_t;

	typedef struct packed {
		logic we;
		logic [NodeBits-1:0] waddr;
		logic [NodeBits-1:0] wlink;
		logic [ValueBits-1:0] wvalue;
		logic wr_value;
		logic [NodeBits-1:0] raddr_a;
		logic [NodeBits-1:0] raddr_b;
	} node_req_t;

	function automatic logic node_ok(input logic [NodeBits-1:0] n);
		return n < NilNode;
	endfunction
endpackage
`default_nettype wire

// ----- sv/msq_node_mem.sv -----
`default_nettype none
module msq_node_mem (
	input wire logic clk,
	input wire msq_pkg::node_req_t req,
	output logic [msq_pkg::NodeBits-1:0] link_a,
	output logic [msq_pkg::ValueBits-1:0] value_a,
	output logic [msq_pkg::NodeBits-1:0] link_b,
	output logic [msq_pkg::ValueBits-1:0] value_b
);
	localparam int Aw = $clog2(msq_pkg::PoolNodes);
	logic [msq_pkg::NodeBits-1:0] link_mem [msq_pkg::PoolNodes];
	logic [msq_pkg::ValueBits-1:0] value_mem [msq_pkg::PoolNodes];

	always_ff @(posedge clk) begin
		if (req.we) begin
			link_mem[req.waddr[Aw-1:0]] <= req.wlink;
			if (req.wr_value) begin
				value_mem[req.waddr[Aw-1:0]] <= req.wvalue;
			end
		end
		link_a <= link_mem[req.raddr_a[Aw-1:0]];
		value_a <= value_mem[req.raddr_a[Aw-1:0]];
		link_b <= link_mem[req.raddr_b[Aw-1:0]];
		value_b <= value_mem[req.raddr_b[Aw-1:0]];
	end
endmodule
`default_nettype wire

// ----- sv/msq_head_mem.sv -----
`default_nettype none
module msq_head_mem (
	input wire logic clk,
	input wire logic we,
	input wire logic [msq_pkg::QueueBits-1:0] waddr,
	input wire logic [msq_pkg::NodeBits-1:0] wdata,
	input wire logic [msq_pkg::QueueBits-1:0] raddr,
	output logic [msq_pkg::NodeBits-1:0] rdata
);
	logic [msq_pkg::NodeBits-1:0] mem [msq_pkg::NumQueues];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- sv/mergeable_sorted_list_queues_unit.sv -----
// Many min-priority queues held as ascending linked lists in one shared
// node pool. The input channel (in_item, in_valid, in_stall) carries one
// operation: merge queue_b into queue_a, pop the head of queue_a, insert
// item_value into queue_a, or none. Every item gives exactly one result on
// the output channel (out_item, out_valid, out_stall).
// One item is worked on at a time. Queue heads and nodes live in
// synchronous memories with registered reads; each list step is one
// node read and one check. The next item is taken in the cycle the
// result appears.
// After reset a clearing pass writes every queue head to empty, one per
// cycle, so no item is taken until the pass is done. The result sits in
// an output register; while the receiver stalls, it holds and no new item
// is taken.
`default_nettype none
module mergeable_sorted_list_queues_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire msq_pkg::in_item_t in_item,
	input wire logic in_valid,
	output logic in_stall,
	output msq_pkg::out_item_t out_item,
	output logic out_valid,
	input wire logic out_stall
);
	localparam int Nb = msq_pkg::NodeBits;
	localparam int Qb = msq_pkg::QueueBits;
	localparam int Vb = msq_pkg::ValueBits;
	localparam logic [Nb-1:0] Nil = msq_pkg::NilNode;

	msq_pkg::state_t state_q, state_d;
	logic clr_q;
	logic [Qb:0] clr_cnt_q;
	msq_pkg::in_item_t item_q;
	logic [Nb-1:0] free_q, fresh_q, pa_q, pb_q, prev_q, tail_q, first_q, newn_q;
	logic [Nb-1:0] free_d, fresh_d, pa_d, pb_d, prev_d, tail_d, first_d, newn_d;
	logic phase_q, phase_d;
	logic [Vb-1:0] pval_q, pval_d;
	logic [1:0] st_q, st_d;

	logic hwe;
	logic [Qb-1:0] hwaddr, hraddr;
	logic [Nb-1:0] hwdata, hrdata;
	msq_pkg::node_req_t nreq;
	logic [Nb-1:0] link_a, link_b;
	logic [Vb-1:0] value_a, value_b;

	msq_head_mem u_head (
		.clk(clk), .we(hwe), .waddr(hwaddr), .wdata(hwdata),
		.raddr(hraddr), .rdata(hrdata)
	);
	msq_node_mem u_node (
		.clk(clk), .req(nreq), .link_a(link_a), .value_a(value_a),
		.link_b(link_b), .value_b(value_b)
	);

	assign in_stall = clr_q || (state_q != msq_pkg::S_IDLE) || (out_valid && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msq_pkg::S_IDLE;
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
			free_q <= Nil;
			fresh_q <= '0;
			out_valid <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			free_q <= free_d;
			fresh_q <= fresh_d;
			phase_q <= phase_d;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == (Qb+1)'(msq_pkg::NumQueues - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (state_q == msq_pkg::S_OUT) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_q <= in_item;
		end
		pa_q <= pa_d;
		pb_q <= pb_d;
		prev_q <= prev_d;
		tail_q <= tail_d;
		first_q <= first_d;
		newn_q <= newn_d;
		pval_q <= pval_d;
		st_q <= st_d;
		if (state_q == msq_pkg::S_OUT) begin
			out_item.popped_value <= pval_d;
			out_item.status <= st_d;
		end
	end

	logic [Nb-1:0] pick, nxt;
	always_comb begin
		state_d = state_q;
		free_d = free_q;
		fresh_d = fresh_q;
		pa_d = pa_q;
		pb_d = pb_q;
		prev_d = prev_q;
		tail_d = tail_q;
		first_d = first_q;
		newn_d = newn_q;
		phase_d = phase_q;
		pval_d = pval_q;
		st_d = st_q;
		pick = Nil;
		nxt = Nil;
		hwe = 1'b0;
		hwaddr = item_q.queue_a;
		hwdata = Nil;
		hraddr = item_q.queue_a;
		nreq = '0;
		nreq.raddr_a = pa_q;
		nreq.raddr_b = pb_q;
		if (clr_q) begin
			hwe = 1'b1;
			hwaddr = clr_cnt_q[Qb-1:0];
		end
		unique case (state_q)
			msq_pkg::S_IDLE: begin
				hraddr = in_item.queue_a;
				phase_d = 1'b0;
				pval_d = '0;
				st_d = msq_pkg::ST_OK;
				// Wait also for the output register to be free.
				if (in_valid && !in_stall && !(out_valid && out_stall)) begin
					state_d = msq_pkg::S_HEADS;
				end
			end
			msq_pkg::S_HEADS: begin
				// Head of A arrived; ask for head of B.
				hraddr = item_q.queue_b;
				pa_d = hrdata;
				nreq.raddr_a = free_q;
				unique case (msq_pkg::op_t'(item_q.operation))
					msq_pkg::OP_MERGE: begin
						state_d = (item_q.queue_a == item_q.queue_b) ? msq_pkg::S_OUT
							: msq_pkg::S_MRG_RD;
						phase_d = 1'b0;
					end
					msq_pkg::OP_POP: begin
						nreq.raddr_a = hrdata;
						if (msq_pkg::node_ok(hrdata)) begin
							state_d = msq_pkg::S_POP_RD;
						end else begin
							st_d = msq_pkg::ST_EMPTY;
							state_d = msq_pkg::S_OUT;
						end
					end
					msq_pkg::OP_INSERT: state_d = msq_pkg::S_ALLOC;
					default: state_d = msq_pkg::S_OUT;
				endcase
			end
			msq_pkg::S_ALLOC: begin
				// link_a holds the link of the free-list head.
				prev_d = Nil;
				if (msq_pkg::node_ok(free_q)) begin
					newn_d = free_q;
					free_d = link_a;
					state_d = msq_pkg::S_INS_RD;
				end else if (fresh_q < Nil) begin
					newn_d = fresh_q;
					fresh_d = fresh_q + 1'b1;
					state_d = msq_pkg::S_INS_RD;
				end else begin
					st_d = msq_pkg::ST_FULL;
					state_d = msq_pkg::S_OUT;
				end
			end
			msq_pkg::S_INS_RD: begin
				if (msq_pkg::node_ok(pa_q)) begin
					state_d = msq_pkg::S_INS_CHK;
				end else begin
					nreq.we = 1'b1;
					nreq.waddr = newn_q;
					nreq.wlink = pa_q;
					nreq.wvalue = item_q.item_value;
					nreq.wr_value = 1'b1;
					state_d = msq_pkg::S_INS_CHK;
					phase_d = 1'b1;
				end
			end
			msq_pkg::S_INS_CHK: begin
				if (!phase_q && value_a < item_q.item_value) begin
					prev_d = pa_q;
					pa_d = link_a;
					state_d = msq_pkg::S_INS_RD;
				end else begin
					if (!phase_q) begin
						nreq.we = 1'b1;
						nreq.waddr = newn_q;
						nreq.wlink = pa_q;
						nreq.wvalue = item_q.item_value;
						nreq.wr_value = 1'b1;
						state_d = msq_pkg::S_MRG_CHK;
					end else begin
						state_d = msq_pkg::S_MRG_CHK;
					end
					phase_d = 1'b1;
				end
			end
			msq_pkg::S_POP_RD: begin
				// pa_q is the head node; link_a / value_a now valid.
				pval_d = value_a;
				hwe = 1'b1;
				hwdata = link_a;
				nreq.we = 1'b1;
				nreq.waddr = pa_q;
				nreq.wlink = free_q;
				free_d = pa_q;
				state_d = msq_pkg::S_OUT;
			end
			msq_pkg::S_MRG_RD: begin
				if (!phase_q) begin
					// Head of B arrived.
					pb_d = hrdata;
					hwe = 1'b1;
					hwaddr = item_q.queue_b;
					hwdata = Nil;
					tail_d = Nil;
					first_d = Nil;
					phase_d = 1'b1;
					if (!msq_pkg::node_ok(pa_q)) begin
						// A is empty: queue_a takes B's list in the finish step.
						state_d = msq_pkg::S_MRG_CHK;
						tail_d = hrdata;
						first_d = Nil;
					end else if (!msq_pkg::node_ok(hrdata)) begin
						state_d = msq_pkg::S_OUT;
					end
				end else begin
					state_d = msq_pkg::S_MRG_CHK;
				end
			end
			msq_pkg::S_MRG_CHK: begin
				if (msq_pkg::op_t'(item_q.operation) == msq_pkg::OP_INSERT) begin
					// Insert finish: hook the new node in.
					if (msq_pkg::node_ok(prev_q)) begin
						nreq.we = 1'b1;
						nreq.waddr = prev_q;
						nreq.wlink = newn_q;
						nreq.wr_value = 1'b0;
					end else begin
						hwe = 1'b1;
						hwdata = newn_q;
					end
					state_d = msq_pkg::S_OUT;
				end else if (!msq_pkg::node_ok(first_q) && !msq_pkg::node_ok(tail_q)
						&& !msq_pkg::node_ok(pa_q)) begin
					state_d = msq_pkg::S_OUT;
				end else if (!msq_pkg::node_ok(pa_q) && !msq_pkg::node_ok(first_q)) begin
					// A was empty: queue_a takes B's list (head in tail_q).
					hwe = 1'b1;
					hwdata = tail_q;
					state_d = msq_pkg::S_OUT;
				end else if (msq_pkg::node_ok(pa_q) && msq_pkg::node_ok(pb_q)) begin
					if (value_a > value_b) begin
						pick = pb_q;
						nxt = link_b;
						pb_d = link_b;
					end else begin
						pick = pa_q;
						nxt = link_a;
						pa_d = link_a;
					end
					if (msq_pkg::node_ok(tail_q)) begin
						nreq.we = 1'b1;
						nreq.waddr = tail_q;
						nreq.wlink = pick;
					end else begin
						first_d = pick;
					end
					tail_d = pick;
					nreq.raddr_a = (pick == pa_q) ? nxt : pa_q;
					nreq.raddr_b = (pick == pb_q) ? nxt : pb_q;
					state_d = msq_pkg::S_MRG_RD;
				end else begin
					nreq.we = 1'b1;
					nreq.waddr = tail_q;
					nreq.wlink = msq_pkg::node_ok(pa_q) ? pa_q : pb_q;
					hwe = 1'b1;
					hwdata = first_q;
					state_d = msq_pkg::S_OUT;
				end
			end
			msq_pkg::S_OUT: begin
				state_d = msq_pkg::S_IDLE;
			end
			default: state_d = msq_pkg::S_IDLE;
		endcase
		if (clr_q) begin
			hwe = 1'b1;
			hwaddr = clr_cnt_q[Qb-1:0];
			hwdata = Nil;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> in_stall)
		else $error("item taken during head clearing");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == msq_pkg::S_HEADS))
		else $error("accepted item did not start");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msq_pkg::S_OUT) |=> out_valid)
		else $error("result not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= Nil)
		else $error("fresh count past pool size");
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none
module tb_top;
	localparam int StallLimit = 40000;

	// Shadow of the queues: each queue is an ascending list of values.
	class list_scoreboard;
		logic [msq_pkg::ValueBits-1:0] lists[msq_pkg::NumQueues][$];
		int nodes_in_use;
		msq_pkg::out_item_t pending[$];
		int errors;

		function new();
			nodes_in_use = 0;
			errors = 0;
		endfunction

		function void note_item(msq_pkg::in_item_t it);
			msq_pkg::out_item_t r;
			logic [msq_pkg::ValueBits-1:0] merged[$];
			logic [msq_pkg::ValueBits-1:0] la[$];
			logic [msq_pkg::ValueBits-1:0] lb[$];
			int pos;
			r = '0;
			r.status = msq_pkg::ST_OK;
			case (msq_pkg::op_t'(it.operation))
			msq_pkg::OP_MERGE: begin
				if (it.queue_a != it.queue_b) begin
					la = lists[it.queue_a];
					lb = lists[it.queue_b];
					while (la.size() > 0 && lb.size() > 0) begin
						if (la[0] > lb[0])
							merged.push_back(lb.pop_front());
						else
							merged.push_back(la.pop_front());
					end
					merged = {merged, la, lb};
					lists[it.queue_a] = merged;
					lists[it.queue_b].delete();
				end
			end
			msq_pkg::OP_POP: begin
				if (lists[it.queue_a].size() == 0) begin
					r.status = msq_pkg::ST_EMPTY;
				end else begin
					r.popped_value = lists[it.queue_a].pop_front();
					nodes_in_use--;
				end
			end
			msq_pkg::OP_INSERT: begin
				if (nodes_in_use >= msq_pkg::PoolNodes) begin
					r.status = msq_pkg::ST_FULL;
				end else begin
					// New value goes ahead of older equal entries.
					pos = 0;
					while (pos < lists[it.queue_a].size() &&
							lists[it.queue_a][pos] < it.item_value)
						pos++;
					lists[it.queue_a].insert(pos, it.item_value);
					nodes_in_use++;
				end
			end
			default: ;
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(msq_pkg::out_item_t got);
			msq_pkg::out_item_t exp_r;
			if (pending.size() == 0) begin
				$error("result with no item outstanding: %h", got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.popped_value !== exp_r.popped_value) begin
				$error("popped_value expected %0d actual %0d",
					exp_r.popped_value, got.popped_value);
				errors++;
			end
			if (got.status !== exp_r.status) begin
				$error("status expected %0d actual %0d", exp_r.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	msq_pkg::in_item_t in_item = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	msq_pkg::out_item_t out_item;
	logic out_valid;
	logic out_stall = 1'b0;

	list_scoreboard board = new();
	int idle_cycles = 0;
	msq_pkg::in_item_t stim_q[$];

	always #5 clk = ~clk;

	mergeable_sorted_list_queues_unit DUT (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .in_valid(in_valid),
		.in_stall(in_stall), .out_item(out_item), .out_valid(out_valid),
		.out_stall(out_stall)
	);

	function automatic msq_pkg::in_item_t make_item(msq_pkg::op_t op, int qa, int qb, int v);
		msq_pkg::in_item_t it;
		it.operation = op;
		it.queue_a = msq_pkg::QueueBits'(qa);
		it.queue_b = msq_pkg::QueueBits'(qb);
		it.item_value = msq_pkg::ValueBits'(v);
		return it;
	endfunction

	// Mostly a few hot queues so lists grow and merges do real work.
	function automatic int pick_queue();
		if ($urandom_range(0, 9) < 8)
			return int'($urandom_range(0, 5));
		return int'($urandom_range(0, msq_pkg::NumQueues - 1));
	endfunction

	function automatic int pick_value();
		case ($urandom_range(0, 3))
		0: return int'($urandom_range(0, 7));
		1: return int'($urandom & 32'h7FFF_FFFF);
		2: return int'(32'h7FFF_FFFF - $urandom_range(0, 3));
		default: return int'($urandom_range(0, 1000));
		endcase
	endfunction

	task automatic send_items();
		int burst;
		int gap;
		while (stim_q.size() > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && stim_q.size() > 0) begin
				in_item <= stim_q.pop_front();
				in_valid <= 1'b1;
				@(posedge clk);
				while (in_stall)
					@(posedge clk);
				burst--;
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	// Accepted items are noted at the same edge the block takes them.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			board.note_item(in_item);
		if (arst_n && out_valid && !out_stall)
			board.check_result(out_item);
	end

	// Receiver stall pattern, with one long hold-off to fill the block.
	initial begin
		int phase;
		phase = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			phase++;
			if (phase == 1500) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
			end else if (phase % 400 < 150) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	// Watchdog on cycles without any accepted item or result.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int k;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part.
		stim_q.push_back(make_item(msq_pkg::OP_POP, 0, 0, 0));
		stim_q.push_back(make_item(msq_pkg::OP_INSERT, 0, 0, 32'h7FFF_FFFF));
		stim_q.push_back(make_item(msq_pkg::OP_INSERT, 0, 0, 0));
		stim_q.push_back(make_item(msq_pkg::OP_INSERT, 0, 0, 5));
		stim_q.push_back(make_item(msq_pkg::OP_INSERT, 0, 0, 5));
		stim_q.push_back(make_item(msq_pkg::OP_INSERT, 1, 0, 5));
		stim_q.push_back(make_item(msq_pkg::OP_INSERT, 1, 0, 2));
		stim_q.push_back(make_item(msq_pkg::OP_INSERT, 1023, 0, 32'h2AAA_AAAA));
		stim_q.push_back(make_item(msq_pkg::OP_MERGE, 0, 1, 0));
		stim_q.push_back(make_item(msq_pkg::OP_MERGE, 0, 0, 0));
		stim_q.push_back(make_item(msq_pkg::OP_MERGE, 1, 0, 0));
		stim_q.push_back(make_item(msq_pkg::OP_POP, 1, 0, 0));
		stim_q.push_back(make_item(msq_pkg::OP_POP, 0, 1, 0));
		stim_q.push_back(make_item(msq_pkg::OP_NONE, 1023, 1023, 32'h7FFF_FFFF));
		stim_q.push_back(make_item(msq_pkg::OP_MERGE, 1023, 1, 32'h5555_5555));
		stim_q.push_back(make_item(msq_pkg::OP_POP, 1023, 0, 0));
		stim_q.push_back(make_item(msq_pkg::OP_POP, 1, 0, 0));
		stim_q.push_back(make_item(msq_pkg::OP_POP, 1, 0, 0));
		send_items();
		@(posedge clk);

		// Random part.
		for (k = 0; k < 270; k++) begin
			case ($urandom_range(0, 9))
			0, 1: stim_q.push_back(make_item(msq_pkg::OP_MERGE, pick_queue(),
				pick_queue(), pick_value()));
			2, 3, 4: stim_q.push_back(make_item(msq_pkg::OP_POP, pick_queue(),
				pick_queue(), pick_value()));
			9: stim_q.push_back(make_item(msq_pkg::OP_NONE, pick_queue(),
				pick_queue(), pick_value()));
			default: stim_q.push_back(make_item(msq_pkg::OP_INSERT, pick_queue(),
				pick_queue(), pick_value()));
			endcase
		end
		send_items();

		while (board.pending.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
